// File: rtl/mrmp_pkg.sv
`default_nettype none

package mrmp_pkg;

  // width of the base and digit fields
  localparam int SMALL_WIDTH = 31;

  // operations of the shared modular multiplier
  typedef enum logic [2:0] {
    OP_RED_B,
    OP_RED_D,
    OP_MUL_S,
    OP_MUL_P,
    OP_SQ_S,
    OP_SQ_P,
    OP_FIN
  } mul_op_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHKM,
    S_RED_B,
    S_RED_D,
    S_LOOP,
    S_MUL_S,
    S_MUL_P,
    S_SQ_S,
    S_SQ_P,
    S_FIN,
    S_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    start;
    mul_op_t op;
    logic    shift;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic done;
    logic n_zero;
    logic n_bit0;
    logic m_small;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/mrmp_ctrl.sv
`default_nettype none

module mrmp_ctrl
  import mrmp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHKM;
      end
      S_CHKM: begin
        state_nxt = sts.m_small ? S_FIN : S_RED_B;
      end
      S_RED_B: begin
        if (sts.done) state_nxt = S_RED_D;
      end
      S_RED_D: begin
        if (sts.done) state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (sts.n_zero) state_nxt = S_FIN;
        else if (sts.n_bit0) state_nxt = S_MUL_S;
        else state_nxt = S_SQ_S;
      end
      S_MUL_S: begin
        if (sts.done) state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        if (sts.done) state_nxt = S_SQ_S;
      end
      S_SQ_S: begin
        if (sts.done) state_nxt = S_SQ_P;
      end
      S_SQ_P: begin
        if (sts.done) state_nxt = S_LOOP;
      end
      S_FIN: begin
        if (sts.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.start    = 1'b0;
    cmd.op       = OP_FIN;
    cmd.shift    = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RED_B: begin
        cmd.op    = OP_RED_B;
        cmd.start = !sts.busy;
      end
      S_RED_D: begin
        cmd.op    = OP_RED_D;
        cmd.start = !sts.busy;
      end
      S_MUL_S: begin
        cmd.op    = OP_MUL_S;
        cmd.start = !sts.busy;
      end
      S_MUL_P: begin
        cmd.op    = OP_MUL_P;
        cmd.start = !sts.busy;
      end
      S_SQ_S: begin
        cmd.op    = OP_SQ_S;
        cmd.start = !sts.busy;
      end
      S_SQ_P: begin
        cmd.op    = OP_SQ_P;
        cmd.start = !sts.busy;
        cmd.shift = sts.done;
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        cmd.start = !sts.busy;
      end
      S_OUT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mrmp_datapath.sv
`default_nettype none

module mrmp_datapath
  import mrmp_pkg::*;
#(
  parameter int COUNT_WIDTH = 63,
  parameter int MOD_WIDTH   = 62
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  sts,
  input  wire logic [COUNT_WIDTH-1:0] in_count,
  input  wire logic [SMALL_WIDTH-1:0] in_base,
  input  wire logic [SMALL_WIDTH-1:0] in_digit,
  input  wire logic [MOD_WIDTH-1:0]   in_modulus,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [MOD_WIDTH-1:0]        out_result
);

  // multiplier operand width: covers the modulus and the raw base or digit
  localparam int YW = (MOD_WIDTH > SMALL_WIDTH) ? MOD_WIDTH : SMALL_WIDTH;

  logic [COUNT_WIDTH-1:0] n_r, n_nxt;
  logic [MOD_WIDTH-1:0]   m_r, m_nxt;
  logic [SMALL_WIDTH-1:0] b_r, b_nxt;
  logic [YW-1:0]          dr_r, dr_nxt;
  logic [MOD_WIDTH-1:0]   res_p_r, res_p_nxt, res_s_r, res_s_nxt;
  logic [MOD_WIDTH-1:0]   pw_p_r, pw_p_nxt, pw_s_r, pw_s_nxt;
  logic [MOD_WIDTH-1:0]   acc_r, acc_nxt, x_r, x_nxt;
  logic [YW-1:0]          y_r, y_nxt;
  logic                   busy_r, busy_nxt;
  mul_op_t                op_r, op_nxt;
  logic [MOD_WIDTH-1:0]   out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                 done;
  logic [MOD_WIDTH-1:0] add_x, acc_step, x_step, addend, wb_sum;
  logic [MOD_WIDTH:0]   acc_sum, x_dbl, m_ext, s_sum;
  logic [MOD_WIDTH-1:0] one_m;

  assign m_ext = {1'b0, m_r};
  assign one_m = MOD_WIDTH'(1);
  assign done  = busy_r && (y_r == '0);

  // one shift-and-add step with conditional subtraction
  always_comb begin
    add_x    = y_r[0] ? x_r : '0;
    acc_sum  = {1'b0, acc_r} + {1'b0, add_x};
    acc_step = (acc_sum >= m_ext) ? MOD_WIDTH'(acc_sum - m_ext) : acc_sum[MOD_WIDTH-1:0];
    x_dbl    = {x_r, 1'b0};
    x_step   = (x_dbl >= m_ext) ? MOD_WIDTH'(x_dbl - m_ext) : x_dbl[MOD_WIDTH-1:0];
  end

  // modular add at writeback of the off-diagonal entries
  always_comb begin
    addend = (op_r == OP_MUL_S) ? res_s_r : pw_s_r;
    s_sum  = {1'b0, acc_r} + {1'b0, addend};
    wb_sum = (s_sum >= m_ext) ? MOD_WIDTH'(s_sum - m_ext) : s_sum[MOD_WIDTH-1:0];
  end

  // next values
  always_comb begin
    n_nxt         = n_r;
    m_nxt         = m_r;
    b_nxt         = b_r;
    dr_nxt        = dr_r;
    res_p_nxt     = res_p_r;
    res_s_nxt     = res_s_r;
    pw_p_nxt      = pw_p_r;
    pw_s_nxt      = pw_s_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    busy_nxt      = busy_r;
    op_nxt        = op_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    // capture a new item
    if (cmd.load) begin
      n_nxt     = in_count;
      m_nxt     = in_modulus;
      b_nxt     = in_base;
      dr_nxt    = YW'(in_digit);
      res_p_nxt = one_m;
      res_s_nxt = '0;
      pw_s_nxt  = one_m;
    end

    // launch a product
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      acc_nxt  = '0;
      case (cmd.op)
        OP_RED_B: begin
          x_nxt = one_m;
          y_nxt = YW'(b_r);
        end
        OP_RED_D: begin
          x_nxt = one_m;
          y_nxt = dr_r;
        end
        OP_MUL_S: begin
          x_nxt = res_p_r;
          y_nxt = YW'(pw_s_r);
        end
        OP_MUL_P: begin
          x_nxt = res_p_r;
          y_nxt = YW'(pw_p_r);
        end
        OP_SQ_S: begin
          x_nxt = pw_p_r;
          y_nxt = YW'(pw_s_r);
        end
        OP_SQ_P: begin
          x_nxt = pw_p_r;
          y_nxt = YW'(pw_p_r);
        end
        OP_FIN: begin
          x_nxt = res_s_r;
          y_nxt = dr_r;
        end
        default: begin
          x_nxt = '0;
          y_nxt = '0;
        end
      endcase
    end else if (busy_r && !done) begin
      acc_nxt = acc_step;
      x_nxt   = x_step;
      y_nxt   = y_r >> 1;
    end

    // write the finished product back; the final product stays in acc
    if (done) begin
      busy_nxt = 1'b0;
      case (op_r)
        OP_RED_B: pw_p_nxt  = acc_r;
        OP_RED_D: dr_nxt    = YW'(acc_r);
        OP_MUL_S: res_s_nxt = wb_sum;
        OP_MUL_P: res_p_nxt = acc_r;
        OP_SQ_S:  pw_s_nxt  = wb_sum;
        OP_SQ_P:  pw_p_nxt  = acc_r;
        default:  busy_nxt  = 1'b0;
      endcase
    end

    // next exponent bit
    if (cmd.shift) begin
      n_nxt = n_r >> 1;
    end

    // output register, loaded only once the previous beat has left
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = acc_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    b_r     <= b_nxt;
    dr_r    <= dr_nxt;
    res_p_r <= res_p_nxt;
    res_s_r <= res_s_nxt;
    pw_p_r  <= pw_p_nxt;
    pw_s_r  <= pw_s_nxt;
    acc_r   <= acc_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    op_r    <= op_nxt;
    out_r   <= out_nxt;
  end

  // status back to the controller
  assign sts.busy     = busy_r;
  assign sts.done     = done;
  assign sts.n_zero   = (n_r == '0);
  assign sts.n_bit0   = n_r[0];
  assign sts.m_small  = (m_r[MOD_WIDTH-1:1] == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

`default_nettype wire

// File: rtl/modular_repdigit_matrix_power.sv
// Modular repeated-digit evaluator: digit written count times in the given
// base, reduced by modulus, via powers of the matrix [[base,1],[0,1]].
// Input channel in_valid/in_ready carries count, base, digit and modulus;
// result channel out_valid/out_ready carries one result per input beat.
// One item is worked at a time. in_ready is high only while the block is
// idle; the result sits in an output register, so the next beat is taken
// once that register is loaded, even while out_ready is still low.
// All products run on one shared bit-serial modular multiplier: a launch,
// one shift-and-add step per multiplier bit and a writeback. Per item: two
// products to reduce base and digit, two or four per bit of count (the
// highest set bit bounds the loop) and one for the final digit multiply.
// A modulus of 0 or 1 skips the loop and returns 0 after the digit
// multiply alone.
// Reset (rst_n low, synchronous) idles the controller and drops out_valid.
// When the receiver stalls, the result holds in the output register and
// the block waits in its final state until that register frees up.
`default_nettype none

module modular_repdigit_matrix_power
  import mrmp_pkg::*;
#(
  parameter int COUNT_WIDTH = 63,
  parameter int MOD_WIDTH   = 62
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COUNT_WIDTH-1:0] in_count,
  input  wire logic [SMALL_WIDTH-1:0] in_base,
  input  wire logic [SMALL_WIDTH-1:0] in_digit,
  input  wire logic [MOD_WIDTH-1:0]   in_modulus,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [MOD_WIDTH-1:0]        out_result
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer
  mrmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // operand registers and shared multiplier
  mrmp_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .MOD_WIDTH   (MOD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_count   (in_count),
    .in_base    (in_base),
    .in_digit   (in_digit),
    .in_modulus (in_modulus),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
